### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the drawing engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RFAB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RFAB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rfab_pkg.sv
// ----------------------------------------------------------------------------
// rfab_pkg
// Types, codes and constants shared by the drawing engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfab_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam int OP_W    = 3;
    localparam int COORD_W = 16;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int ALPHA_W = 9;
    localparam int CANVAS_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W  = 2;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 9'd256;

    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_PIXEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_BLEND_PIX  = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL_RECT  = 3'd3;
    localparam logic [OP_W-1:0] OP_BLEND_RECT = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_PIXEL = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        K_NONE  = 2'd0,
        K_FILL  = 2'd1,
        K_BLEND = 2'd2,
        K_READ  = 2'd3
    } kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int coord_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int entry_width(input int xw, input int yw);
        return KIND_W + 2 * xw + 2 * yw + PIX_W + ALPHA_W;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rfab_queue.sv
// ----------------------------------------------------------------------------
// rfab_queue
// Small register FIFO that carries classified commands to the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rfab_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DW-1:0]     push_data,
    input  logic              pop,
    output logic [DW-1:0]     pop_data,
    output rfab_pkg::q_stat_t q_stat
);
    import rfab_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] entry_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CW'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

### rtl/core/rfab_front.sv
// ----------------------------------------------------------------------------
// rfab_front
// Takes commands, holds the canvas registers, clips each command against the
// canvas and queues it as a pixel span with a kind.
// ----------------------------------------------------------------------------
`default_nettype none

module rfab_front #(
    parameter int MAX_WIDTH  = rfab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rfab_pkg::DEF_MAX_HEIGHT,
    parameter int EW         = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rfab_pkg::OP_W-1:0]         op,
    input  logic signed [rfab_pkg::COORD_W-1:0] x_pos,
    input  logic signed [rfab_pkg::COORD_W-1:0] y_pos,
    input  logic signed [rfab_pkg::COORD_W-1:0] box_width,
    input  logic signed [rfab_pkg::COORD_W-1:0] box_height,
    input  logic [rfab_pkg::CH_W-1:0]         red,
    input  logic [rfab_pkg::CH_W-1:0]         green,
    input  logic [rfab_pkg::CH_W-1:0]         blue,
    input  logic [rfab_pkg::ALPHA_W-1:0]      alpha,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfab_pkg::CANVAS_W-1:0]     cfg_data,
    input  logic                              clearing,
    input  rfab_pkg::q_stat_t                 q_stat,
    output logic                              push,
    output logic [EW-1:0]                     push_data
);
    import rfab_pkg::*;

    localparam int XW = coord_width(MAX_WIDTH);
    localparam int YW = coord_width(MAX_HEIGHT);
    localparam int SW = COORD_W + 2;
    localparam logic signed [SW-1:0] ONE_S = SW'(1);

    typedef struct packed {
        kind_t               kind;
        logic [XW-1:0]       x_first;
        logic [XW-1:0]       x_last;
        logic [YW-1:0]       y_first;
        logic [YW-1:0]       y_last;
        logic [PIX_W-1:0]    colour;
        logic [ALPHA_W-1:0]  alpha;
    } entry_t;

    logic                       fr_valid_reg, fr_valid_next;
    logic [OP_W-1:0]            op_reg;
    logic signed [COORD_W-1:0]  x_reg, y_reg, w_reg, h_reg;
    logic [PIX_W-1:0]           colour_reg;
    logic [ALPHA_W-1:0]         alpha_reg;
    logic [CANVAS_W-1:0]        canvas_width_reg, canvas_height_reg;

    logic                       accept;
    logic [CANVAS_W-1:0]        cw_act, ch_act;
    logic signed [SW-1:0]       x_s, y_s, w_s, h_s, cw_s, ch_s;
    logic signed [SW-1:0]       x_end, y_end, x_lm, y_lm, x_fm, y_fm;
    logic                       canvas_ok, on_canvas, rect_ok;
    logic [ALPHA_W-1:0]         alpha_sat;
    entry_t                     ent;

    assign busy      = clearing || (fr_valid_reg && q_stat.full);
    assign accept    = start && !busy;
    assign push      = fr_valid_reg && !q_stat.full;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg      <= 1'b0;
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                    CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            x_reg      <= x_pos;
            y_reg      <= y_pos;
            w_reg      <= box_width;
            h_reg      <= box_height;
            colour_reg <= {red, green, blue};
            alpha_reg  <= alpha;
        end
    end

    always_comb
    begin
        cw_act = (32'(canvas_width_reg) > MAX_WIDTH) ? CANVAS_W'(MAX_WIDTH) : canvas_width_reg;
        ch_act = (32'(canvas_height_reg) > MAX_HEIGHT) ?
                 CANVAS_W'(MAX_HEIGHT) : canvas_height_reg;
        canvas_ok = (cw_act != '0) && (ch_act != '0);

        x_s  = $signed({{2{x_reg[COORD_W-1]}}, x_reg});
        y_s  = $signed({{2{y_reg[COORD_W-1]}}, y_reg});
        w_s  = $signed({{2{w_reg[COORD_W-1]}}, w_reg});
        h_s  = $signed({{2{h_reg[COORD_W-1]}}, h_reg});
        cw_s = $signed({{(SW - CANVAS_W){1'b0}}, cw_act});
        ch_s = $signed({{(SW - CANVAS_W){1'b0}}, ch_act});

        x_end = x_s + w_s;
        y_end = y_s + h_s;
        x_lm  = (x_end < cw_s) ? x_end - ONE_S : cw_s - ONE_S;
        y_lm  = (y_end < ch_s) ? y_end - ONE_S : ch_s - ONE_S;
        x_fm  = (x_s < 0) ? '0 : x_s;
        y_fm  = (y_s < 0) ? '0 : y_s;

        on_canvas = canvas_ok && (x_s >= 0) && (x_s < cw_s) && (y_s >= 0) && (y_s < ch_s);
        rect_ok = canvas_ok && (w_s > 0) && (h_s > 0) && (x_s < cw_s) && (x_end > 0)
                  && (y_s < ch_s) && (y_end > 0);

        alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

        ent.kind    = K_NONE;
        ent.x_first = XW'(x_s);
        ent.x_last  = XW'(x_s);
        ent.y_first = YW'(y_s);
        ent.y_last  = YW'(y_s);
        ent.colour  = colour_reg;
        ent.alpha   = alpha_sat;

        unique case (op_reg) inside
            OP_CLEAR:
            begin
                ent.kind    = canvas_ok ? K_FILL : K_NONE;
                ent.x_first = '0;
                ent.y_first = '0;
                ent.x_last  = XW'(cw_s - ONE_S);
                ent.y_last  = YW'(ch_s - ONE_S);
            end
            OP_SET_PIXEL:  ent.kind = on_canvas ? K_FILL : K_NONE;
            OP_BLEND_PIX:  ent.kind = on_canvas ? K_BLEND : K_NONE;
            OP_READ_PIXEL: ent.kind = on_canvas ? K_READ : K_NONE;
            OP_FILL_RECT, OP_BLEND_RECT:
            begin
                ent.kind    = !rect_ok ? K_NONE : ((op_reg == OP_FILL_RECT) ? K_FILL : K_BLEND);
                ent.x_first = XW'(x_fm);
                ent.y_first = YW'(y_fm);
                ent.x_last  = XW'(x_lm);
                ent.y_last  = YW'(y_lm);
            end
            default: ent.kind = K_NONE;
        endcase
    end

    assign push_data = EW'(ent);

endmodule

`default_nettype wire

### rtl/core/rfab_back.sv
// ----------------------------------------------------------------------------
// rfab_back
// Owns the frame store. Clears it after reset, then walks each queued span one
// pixel per cycle, filling, blending or reading, and issues one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module rfab_back #(
    parameter int MAX_WIDTH  = rfab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rfab_pkg::DEF_MAX_HEIGHT,
    parameter int EW         = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rfab_pkg::q_stat_t           q_stat,
    input  logic [EW-1:0]               q_data,
    output logic                        pop,
    output logic                        clearing,
    output logic                        done,
    output logic                        status,
    output logic [rfab_pkg::CH_W-1:0]   read_red,
    output logic [rfab_pkg::CH_W-1:0]   read_green,
    output logic [rfab_pkg::CH_W-1:0]   read_blue
);
    import rfab_pkg::*;

    localparam int XW    = coord_width(MAX_WIDTH);
    localparam int YW    = coord_width(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = coord_width(DEPTH);

    typedef struct packed {
        kind_t               kind;
        logic [XW-1:0]       x_first;
        logic [XW-1:0]       x_last;
        logic [YW-1:0]       y_first;
        logic [YW-1:0]       y_last;
        logic [PIX_W-1:0]    colour;
        logic [ALPHA_W-1:0]  alpha;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] dst,
                                                    input logic [CH_W-1:0] src,
                                                    input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] na;
        logic [CH_W+ALPHA_W:0] acc;
        na  = ALPHA_ONE - a;
        acc = (CH_W + ALPHA_W + 1)'(dst * na) + (CH_W + ALPHA_W + 1)'(src * a);
        return acc[CH_W +: CH_W];
    endfunction

    state_t              state_reg, state_next;
    entry_t              cmd_reg, cmd_next, q_ent;
    logic [XW-1:0]       xcur_reg, xcur_next;
    logic [YW-1:0]       ycur_reg, ycur_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                pend_wr_reg, pend_wr_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic [PIX_W-1:0]    rd_data_reg;
    logic                done_reg, done_next;
    logic                status_reg, status_next;
    logic [PIX_W-1:0]    rgb_reg, rgb_next;

    logic [PIX_W-1:0]    mem [DEPTH];
    logic [AW-1:0]       addr;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [PIX_W-1:0]    wdata;
    logic [PIX_W-1:0]    mixed;

    assign q_ent    = entry_t'(q_data);
    assign clearing = (state_reg == S_CLEAR);
    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;
    assign addr     = AW'(ycur_reg) * AW'(MAX_WIDTH) + AW'(xcur_reg);

    assign mixed = {mix_channel(rd_data_reg[2*CH_W +: CH_W], cmd_reg.colour[2*CH_W +: CH_W],
                                cmd_reg.alpha),
                    mix_channel(rd_data_reg[CH_W +: CH_W], cmd_reg.colour[CH_W +: CH_W],
                                cmd_reg.alpha),
                    mix_channel(rd_data_reg[0 +: CH_W], cmd_reg.colour[0 +: CH_W],
                                cmd_reg.alpha)};

    always_comb
    begin
        we    = 1'b0;
        waddr = addr;
        wdata = cmd_reg.colour;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (pend_wr_reg)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = mixed;
        end
        else if ((state_reg == S_WALK) && (cmd_reg.kind == K_FILL))
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        xcur_next      = xcur_reg;
        ycur_next      = ycur_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_wr_next   = 1'b0;
        pend_addr_next = addr;
        done_next      = 1'b0;
        status_next    = status_reg;
        rgb_next       = rgb_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    cmd_next   = q_ent;
                    xcur_next  = q_ent.x_first;
                    ycur_next  = q_ent.y_first;
                    state_next = (q_ent.kind == K_NONE) ? S_FINISH : S_WALK;
                end
            end
            S_WALK:
            begin
                pend_wr_next = (cmd_reg.kind == K_BLEND);
                if (xcur_reg == cmd_reg.x_last)
                begin
                    xcur_next = cmd_reg.x_first;
                    if (ycur_reg == cmd_reg.y_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ycur_next = ycur_reg + 1'b1;
                    end
                end
                else
                begin
                    xcur_next = xcur_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                done_next   = 1'b1;
                status_next = (cmd_reg.kind == K_NONE);
                rgb_next    = (cmd_reg.kind == K_READ) ? rd_data_reg : '0;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pend_wr_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_wr_reg <= pend_wr_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        xcur_reg      <= xcur_next;
        ycur_reg      <= ycur_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        rgb_reg       <= rgb_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_red   = rgb_reg[2*CH_W +: CH_W];
    assign read_green = rgb_reg[CH_W +: CH_W];
    assign read_blue  = rgb_reg[0 +: CH_W];

endmodule

`default_nettype wire

### rtl/core/rect_fill_alpha_blend_engine_top.sv
// ----------------------------------------------------------------------------
// rect_fill_alpha_blend_engine_top
// RGB888 drawing engine: clear, set, blend, fill and read on a clipped canvas.
//
//   Channel    Signals                                   Handshake
//   command    op, x_pos, y_pos, box_width, box_height   start / busy
//              red, green, blue, alpha
//   result     status, read_red, read_green, read_blue   done strobe
//   config     cfg_index, cfg_data                       cfg_valid / cfg_ready
//
// After reset the frame store is swept to black, one pixel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels (4096 by default); busy stays high meanwhile.
// Each command occupies the pixel engine while it walks its clipped area, one
// pixel per cycle, and while it issues the result. A command is registered in
// the front end, queued and walked before its result is registered and shown.
// Results cannot be stalled; a four-entry queue lets commands be taken while
// earlier ones are still drawing.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_fill_alpha_blend_engine_top #(
    parameter int MAX_WIDTH  = rfab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rfab_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rfab_pkg::OP_W-1:0]           op,
    input  logic signed [rfab_pkg::COORD_W-1:0] x_pos,
    input  logic signed [rfab_pkg::COORD_W-1:0] y_pos,
    input  logic signed [rfab_pkg::COORD_W-1:0] box_width,
    input  logic signed [rfab_pkg::COORD_W-1:0] box_height,
    input  logic [rfab_pkg::CH_W-1:0]           red,
    input  logic [rfab_pkg::CH_W-1:0]           green,
    input  logic [rfab_pkg::CH_W-1:0]           blue,
    input  logic [rfab_pkg::ALPHA_W-1:0]        alpha,
    output logic                                done,
    output logic                                status,
    output logic [rfab_pkg::CH_W-1:0]           read_red,
    output logic [rfab_pkg::CH_W-1:0]           read_green,
    output logic [rfab_pkg::CH_W-1:0]           read_blue,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rfab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfab_pkg::CANVAS_W-1:0]       cfg_data
);
    import rfab_pkg::*;

    localparam int EW = entry_width(coord_width(MAX_WIDTH), coord_width(MAX_HEIGHT));

    q_stat_t        q_stat;
    logic           push, pop, clearing;
    logic [EW-1:0]  push_data, pop_data;

    rfab_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .EW         (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .box_width   (box_width),
        .box_height  (box_height),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .clearing    (clearing),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    rfab_queue #(
        .DW    (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rfab_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .EW         (EW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_data     (pop_data),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .status     (status),
        .read_red   (read_red),
        .read_green (read_green),
        .read_blue  (read_blue)
    );

endmodule

`default_nettype wire

### rtl/core/rfab_checker.sv
// ----------------------------------------------------------------------------
// rfab_checker
// Port-level checks on the drawing engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfab_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           done,
    input  logic                           status,
    input  logic [rfab_pkg::CH_W-1:0]      read_red,
    input  logic [rfab_pkg::CH_W-1:0]      read_green,
    input  logic [rfab_pkg::CH_W-1:0]      read_blue,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready
);
    import rfab_pkg::*;

    logic [3:0] open_reg, open_next;
    logic       rgb_zero;

    assign rgb_zero = (read_red == '0) && (read_green == '0) && (read_blue == '0);

    always_comb
    begin
        open_next = open_reg;
        if ((start && !busy) && !done)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (done && !(start && !busy))
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `RFAB_ASSERT_IMP(a_done_has_cmd, done, open_reg != 4'd0, "result with no open transaction")
    `RFAB_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `RFAB_ASSERT_IMP(a_fail_no_data, done && status, rgb_zero, "failed transaction has pixel data")
    `RFAB_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write held off")

endmodule

bind rect_fill_alpha_blend_engine_top rfab_checker u_rfab_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .read_red   (read_red),
    .read_green (read_green),
    .read_blue  (read_blue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire
